// ===== src/sic_pkg.sv =====
package sic_pkg;

	// contact classes reported on contact_kind
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_POINT   = 2'd1;
	localparam logic [1:0] KIND_OVERLAP = 2'd2;

	// control that travels down the pipeline next to the data
	typedef struct packed {
		logic valid;
		logic a_point;
	} sic_ctl_t;

endpackage

// ===== src/sic_cross.sv =====
module sic_cross #(
	parameter int W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sic_pkg::sic_ctl_t     ctl_s1,
	input  logic signed [W:0]     dax_s1,
	input  logic signed [W:0]     day_s1,
	input  logic signed [W:0]     dbx_s1,
	input  logic signed [W:0]     dby_s1,
	input  logic signed [W:0]     ox_s1,
	input  logic signed [W:0]     oy_s1,
	input  logic signed [W:0]     ex_s1,
	input  logic signed [W:0]     ey_s1,
	output sic_pkg::sic_ctl_t     ctl_s3,
	output logic signed [2*W+2:0] d_s3,
	output logic signed [2*W+2:0] na_s3,
	output logic signed [2*W+2:0] nb_s3,
	output logic signed [2*W+2:0] o2_s3
);
	import sic_pkg::*;

	localparam int P = 2 * W + 2;

	sic_ctl_t            ctl_s2;
	logic signed [P-1:0] p_d0_s2, p_d1_s2;
	logic signed [P-1:0] p_a0_s2, p_a1_s2;
	logic signed [P-1:0] p_b0_s2, p_b1_s2;
	logic signed [P-1:0] p_o0_s2, p_o1_s2;

	// control valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// cross products, one multiplier per term
	always_ff @(posedge clk) begin
		p_d0_s2 <= dax_s1 * dby_s1;
		p_d1_s2 <= day_s1 * dbx_s1;
		p_a0_s2 <= dby_s1 * ox_s1;
		p_a1_s2 <= dbx_s1 * oy_s1;
		p_b0_s2 <= dax_s1 * oy_s1;
		p_b1_s2 <= day_s1 * ox_s1;
		p_o0_s2 <= day_s1 * ex_s1;
		p_o1_s2 <= dax_s1 * ey_s1;
	end

	// determinant, both numerators and the second orientation
	always_ff @(posedge clk) begin
		d_s3  <= {p_d0_s2[P-1], p_d0_s2} - {p_d1_s2[P-1], p_d1_s2};
		na_s3 <= {p_a0_s2[P-1], p_a0_s2} - {p_a1_s2[P-1], p_a1_s2};
		nb_s3 <= {p_b0_s2[P-1], p_b0_s2} - {p_b1_s2[P-1], p_b1_s2};
		o2_s3 <= {p_o0_s2[P-1], p_o0_s2} - {p_o1_s2[P-1], p_o1_s2};
	end

endmodule

// ===== src/segment_intersection_classify.sv =====
// Segment intersection classifier.
// Input channel: drive the eight endpoint coordinates and raise start for
// one cycle; a transaction is accepted at each rising edge with start high
// and busy low. busy is always low, so a new segment pair may be issued on
// every cycle.
// Output channel: done is high for exactly one cycle with contact_kind
// valid in that cycle (0 disjoint, 1 single point, 2 collinear overlap).
// Throughput is one pair per cycle, set by the four-register pipeline (input
// register, product register, sum register, result register) with a multiplier
// per cross term. Results leave in acceptance order. The receiver cannot stall;
// a result is on the ports for one cycle only.
// Reset (arst_n low) clears all valid bits so no done pulse appears for
// work in flight; the data registers are not reset.
module segment_intersection_classify #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_end_x,
	input  logic signed [COORD_BITS-1:0] a_end_y,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_end_x,
	input  logic signed [COORD_BITS-1:0] b_end_y,
	output logic                         done,
	output logic [1:0]                   contact_kind
);
	import sic_pkg::*;

	localparam int W = COORD_BITS;
	localparam int S = 2 * W + 3;

	logic signed [W:0]   dax, day, dbx, dby, ox, oy, ex, ey;
	logic signed [W-1:0] a0, a1, b0, b1;
	logic                vert;
	sic_ctl_t            ctl_in;

	sic_ctl_t            ctl_s1, ctl_s3;
	logic signed [W:0]   dax_s1, day_s1, dbx_s1, dby_s1, ox_s1, oy_s1, ex_s1, ey_s1;
	logic signed [W-1:0] a0_s1, a1_s1, b0_s1, b1_s1;
	logic signed [W-1:0] hi_min_s2, lo_max_s2;
	logic signed [W:0]   overlap_s3;
	logic signed [S-1:0] d_s3, na_s3, nb_s3, o2_s3;

	logic signed [W-1:0] ahi, alo, bhi, blo;
	logic [S-1:0]        d_mag, na_mag, nb_mag;
	logic                ok_a, ok_b, collinear;
	logic [1:0]          kind;

	assign busy = 1'b0;

	// endpoint differences and projection axis choice
	always_comb begin
		dax  = {a_start_x[W-1], a_start_x} - {a_end_x[W-1], a_end_x};
		day  = {a_start_y[W-1], a_start_y} - {a_end_y[W-1], a_end_y};
		dbx  = {b_end_x[W-1], b_end_x} - {b_start_x[W-1], b_start_x};
		dby  = {b_end_y[W-1], b_end_y} - {b_start_y[W-1], b_start_y};
		ox   = {a_start_x[W-1], a_start_x} - {b_start_x[W-1], b_start_x};
		oy   = {a_start_y[W-1], a_start_y} - {b_start_y[W-1], b_start_y};
		ex   = {b_end_x[W-1], b_end_x} - {a_start_x[W-1], a_start_x};
		ey   = {b_end_y[W-1], b_end_y} - {a_start_y[W-1], a_start_y};
		vert = (a_start_x == a_end_x) && (a_start_x == b_start_x) &&
		       (a_start_x == b_end_x);
		if (vert) begin
			a0 = a_start_y; a1 = a_end_y; b0 = b_start_y; b1 = b_end_y;
		end else begin
			a0 = a_start_x; a1 = a_end_x; b0 = b_start_x; b1 = b_end_x;
		end
		ctl_in.valid   = start;
		ctl_in.a_point = (a_start_x == a_end_x) && (a_start_y == a_end_y);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		dax_s1 <= dax; day_s1 <= day; dbx_s1 <= dbx; dby_s1 <= dby;
		ox_s1  <= ox;  oy_s1  <= oy;  ex_s1  <= ex;  ey_s1  <= ey;
		a0_s1  <= a0;  a1_s1  <= a1;  b0_s1  <= b0;  b1_s1  <= b1;
	end

	// products and cross sums
	sic_cross #(
		.W(W)
	) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.dax_s1 (dax_s1),
		.day_s1 (day_s1),
		.dbx_s1 (dbx_s1),
		.dby_s1 (dby_s1),
		.ox_s1  (ox_s1),
		.oy_s1  (oy_s1),
		.ex_s1  (ex_s1),
		.ey_s1  (ey_s1),
		.ctl_s3 (ctl_s3),
		.d_s3   (d_s3),
		.na_s3  (na_s3),
		.nb_s3  (nb_s3),
		.o2_s3  (o2_s3)
	);

	// projected range ends
	always_comb begin
		ahi = (a0_s1 > a1_s1) ? a0_s1 : a1_s1;
		alo = (a0_s1 < a1_s1) ? a0_s1 : a1_s1;
		bhi = (b0_s1 > b1_s1) ? b0_s1 : b1_s1;
		blo = (b0_s1 < b1_s1) ? b0_s1 : b1_s1;
	end

	always_ff @(posedge clk) begin
		hi_min_s2  <= (ahi < bhi) ? ahi : bhi;
		lo_max_s2  <= (alo > blo) ? alo : blo;
		overlap_s3 <= {hi_min_s2[W-1], hi_min_s2} - {lo_max_s2[W-1], lo_max_s2};
	end

	// final classification
	always_comb begin
		d_mag  = d_s3[S-1]  ? S'(-d_s3)  : S'(d_s3);
		na_mag = na_s3[S-1] ? S'(-na_s3) : S'(na_s3);
		nb_mag = nb_s3[S-1] ? S'(-nb_s3) : S'(nb_s3);
		ok_a = ((na_s3 == '0) || (na_s3[S-1] == d_s3[S-1])) && (na_mag <= d_mag);
		ok_b = ((nb_s3 == '0) || (nb_s3[S-1] == d_s3[S-1])) && (nb_mag <= d_mag);
		// point A tests against line B through na, else B ends against line A
		collinear = ctl_s3.a_point ? (na_s3 == '0) : ((nb_s3 == '0) && (o2_s3 == '0));
		if (d_s3 != '0) begin
			kind = (ok_a && ok_b) ? KIND_POINT : KIND_NONE;
		end else if (!collinear || overlap_s3[W]) begin
			kind = KIND_NONE;
		end else if (overlap_s3 == '0) begin
			kind = KIND_POINT;
		end else begin
			kind = KIND_OVERLAP;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		contact_kind <= kind;
	end

endmodule

// ===== test/sic_contact_check.sv =====
module sic_contact_check #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_end_x,
	input  logic signed [COORD_BITS-1:0] a_end_y,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_end_x,
	input  logic signed [COORD_BITS-1:0] b_end_y,
	input  logic                         done,
	input  logic [1:0]                   contact_kind,
	output int                           mismatches,
	output int                           pending
);

	import sic_pkg::*;

	// one accepted segment pair and the contact class it should produce
	typedef struct {
		logic [1:0] kind;
		longint     ax0, ay0, ax1, ay1;
		longint     bx0, by0, bx1, by1;
	} pair_kind_t;

	pair_kind_t expected_kinds[$];
	pair_kind_t head;
	pair_kind_t fresh;

	// twice the signed area of triangle o, p, q
	function automatic longint turn(input longint ox, oy, px, py, qx, qy);
		return (px - ox) * (qy - oy) - (py - oy) * (qx - ox);
	endfunction

	function automatic int sign_of(input longint v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic longint abs_of(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint lo_of(input longint a, b);
		return (a < b) ? a : b;
	endfunction

	function automatic longint hi_of(input longint a, b);
		return (a > b) ? a : b;
	endfunction

	// contact class of segments a and b
	function automatic logic [1:0] classify_contact(input longint ax0, ay0, ax1, ay1,
			input longint bx0, by0, bx1, by1);
		longint dax, day, dbx, dby, ox, oy, det, na, nb;
		longint pa0, pa1, pb0, pb1, reach;
		bit     fit_a, fit_b;
		dax = ax0 - ax1;
		day = ay0 - ay1;
		dbx = bx1 - bx0;
		dby = by1 - by0;
		ox  = ax0 - bx0;
		oy  = ay0 - by0;
		det = dax * dby - day * dbx;
		// crossing lines: both parameters must fall in [0, 1]
		if (det != 0) begin
			na = dby * ox - dbx * oy;
			nb = dax * oy - day * ox;
			fit_a = (na == 0 || sign_of(na) == sign_of(det)) &&
				abs_of(na) <= abs_of(det);
			fit_b = (nb == 0 || sign_of(nb) == sign_of(det)) &&
				abs_of(nb) <= abs_of(det);
			return (fit_a && fit_b) ? KIND_POINT : KIND_NONE;
		end
		// parallel but off the common line
		if (ax0 == ax1 && ay0 == ay1) begin
			if (turn(bx0, by0, bx1, by1, ax0, ay0) != 0)
				return KIND_NONE;
		end else if (turn(ax0, ay0, ax1, ay1, bx0, by0) != 0 ||
				turn(ax0, ay0, ax1, ay1, bx1, by1) != 0) begin
			return KIND_NONE;
		end
		// collinear: compare ranges on x, or on y for a vertical line
		if (ax0 == ax1 && ax0 == bx0 && ax0 == bx1) begin
			pa0 = ay0; pa1 = ay1; pb0 = by0; pb1 = by1;
		end else begin
			pa0 = ax0; pa1 = ax1; pb0 = bx0; pb1 = bx1;
		end
		reach = lo_of(hi_of(pa0, pa1), hi_of(pb0, pb1)) -
			hi_of(lo_of(pa0, pa1), lo_of(pb0, pb1));
		if (reach < 0)
			return KIND_NONE;
		return (reach == 0) ? KIND_POINT : KIND_OVERLAP;
	endfunction

	// retire results first, then record the transaction accepted at this edge
	always @(posedge clk) begin
		if (!arst_n) begin
			mismatches = 0;
			pending    = 0;
		end else begin
			if (done) begin
				if (expected_kinds.size() == 0) begin
					mismatches++;
					$display("%0t: result with no transaction pending: expected none, got %0d",
						$time, contact_kind);
				end else begin
					head = expected_kinds.pop_front();
					if (contact_kind !== head.kind) begin
						mismatches++;
						$display("%0t: contact_kind for A(%0d,%0d)-(%0d,%0d) %s",
							$time, head.ax0, head.ay0, head.ax1, head.ay1,
							"and B below");
						$display("%0t: B(%0d,%0d)-(%0d,%0d): expected %0d, got %0d",
							$time, head.bx0, head.by0, head.bx1, head.by1,
							head.kind, contact_kind);
					end
				end
			end
			if (start && !busy) begin
				fresh.ax0  = longint'(a_start_x);
				fresh.ay0  = longint'(a_start_y);
				fresh.ax1  = longint'(a_end_x);
				fresh.ay1  = longint'(a_end_y);
				fresh.bx0  = longint'(b_start_x);
				fresh.by0  = longint'(b_start_y);
				fresh.bx1  = longint'(b_end_x);
				fresh.by1  = longint'(b_end_y);
				fresh.kind = classify_contact(fresh.ax0, fresh.ay0, fresh.ax1, fresh.ay1,
					fresh.bx0, fresh.by0, fresh.bx1, fresh.by1);
				expected_kinds.insert(expected_kinds.size(), fresh);
			end
			pending = expected_kinds.size();
		end
	end

endmodule

// ===== test/tb.sv =====
module tb;

	localparam int COORD_BITS = 16;
	localparam int RANDOM_PAIRS = 1850;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic signed [COORD_BITS-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
	logic signed [COORD_BITS-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
	logic                         done;
	logic [1:0]                   contact_kind;
	int                           mismatches;
	int                           pending;

	// endpoint coordinates of the next pair: A start, A end, B start, B end
	int coord[8];

	segment_intersection_classify #(.COORD_BITS(COORD_BITS)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.a_start_x    (a_start_x),
		.a_start_y    (a_start_y),
		.a_end_x      (a_end_x),
		.a_end_y      (a_end_y),
		.b_start_x    (b_start_x),
		.b_start_y    (b_start_y),
		.b_end_x      (b_end_x),
		.b_end_y      (b_end_y),
		.done         (done),
		.contact_kind (contact_kind)
	);

	sic_contact_check #(.COORD_BITS(COORD_BITS)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.a_start_x    (a_start_x),
		.a_start_y    (a_start_y),
		.a_end_x      (a_end_x),
		.a_end_y      (a_end_y),
		.b_start_x    (b_start_x),
		.b_start_y    (b_start_y),
		.b_end_x      (b_end_x),
		.b_end_y      (b_end_y),
		.done         (done),
		.contact_kind (contact_kind),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#2000000;
		$display("segment_intersection_classify verification failed");
		$finish;
	end

	function automatic int span_rand(input int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(0, 6))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return 32766;
			default: return 32767;
		endcase
	endfunction

	// issue coord[] at this edge and wait for the transaction to be taken
	task automatic send_pair();
		a_start_x <= COORD_BITS'(coord[0]);
		a_start_y <= COORD_BITS'(coord[1]);
		a_end_x   <= COORD_BITS'(coord[2]);
		a_end_y   <= COORD_BITS'(coord[3]);
		b_start_x <= COORD_BITS'(coord[4]);
		b_start_y <= COORD_BITS'(coord[5]);
		b_end_x   <= COORD_BITS'(coord[6]);
		b_end_y   <= COORD_BITS'(coord[7]);
		start     <= 1'b1;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_coords(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
		coord[0] = ax0; coord[1] = ay0; coord[2] = ax1; coord[3] = ay1;
		coord[4] = bx0; coord[5] = by0; coord[6] = bx1; coord[7] = by1;
		send_pair();
	endtask

	// random pair, weighted toward touching, parallel and collinear layouts
	task automatic fill_random();
		int mode, bx, by, dx, dy, ex, ey, r, k;
		int t[4];
		r = $urandom_range(0, 19);
		if (r < 3) mode = 0;
		else if (r < 7) mode = 1;
		else if (r < 10) mode = 2;
		else if (r < 11) mode = 3;
		else if (r < 12) mode = 4;
		else if (r < 14) mode = 5;
		else if (r < 16) mode = 6;
		else if (r < 17) mode = 7;
		else if (r < 18) mode = 8;
		else mode = 9;
		case (mode)
			// full range noise
			0: begin
				for (k = 0; k < 8; k++)
					coord[k] = int'($urandom_range(0, 65535)) - 32768;
			end
			// tiny box, lots of crossings and touches
			1: begin
				for (k = 0; k < 8; k++)
					coord[k] = span_rand(6);
			end
			// shared endpoint, sometimes the same segment reversed
			6: begin
				for (k = 0; k < 8; k++)
					coord[k] = span_rand(50);
				k = $urandom_range(0, 1) * 2;
				coord[4] = coord[k];
				coord[5] = coord[k + 1];
				if ($urandom_range(0, 3) == 0) begin
					coord[6] = coord[2 - k];
					coord[7] = coord[3 - k];
				end
			end
			// coordinates at the ends of the range
			7: begin
				for (k = 0; k < 8; k++)
					coord[k] = extreme_coord();
			end
			// degenerate point segments
			8: begin
				for (k = 0; k < 8; k++)
					coord[k] = span_rand(6);
				r = $urandom_range(0, 2);
				if (r != 1) begin
					coord[2] = coord[0];
					coord[3] = coord[1];
				end
				if (r != 0) begin
					coord[6] = coord[4];
					coord[7] = coord[5];
				end
			end
			// collinear family: general, vertical, horizontal, shifted, wide
			default: begin
				if (mode == 9) begin
					bx = span_rand(10000);
					by = span_rand(10000);
					dx = span_rand(300);
					dy = span_rand(300);
					for (k = 0; k < 4; k++)
						t[k] = span_rand(50);
				end else begin
					bx = span_rand(2000);
					by = span_rand(2000);
					dx = span_rand(12);
					dy = span_rand(12);
					for (k = 0; k < 4; k++)
						t[k] = span_rand(40);
				end
				if (mode == 3)
					dx = 0;
				if (mode == 4)
					dy = 0;
				for (k = 0; k < 4; k++) begin
					coord[2 * k]     = bx + t[k] * dx;
					coord[2 * k + 1] = by + t[k] * dy;
				end
				if (mode == 5) begin
					ex = span_rand(3);
					ey = span_rand(3);
					coord[4] += ex;
					coord[5] += ey;
					coord[6] += ex;
					coord[7] += ey;
				end
			end
		endcase
	endtask

	// directed corner cases
	task automatic send_directed();
		send_coords(0, 0, 0, 0, 0, 0, 0, 0);
		send_coords(3, 4, 3, 4, 5, 4, 5, 4);
		send_coords(0, 0, 10, 10, 0, 10, 10, 0);
		send_coords(0, 0, 10, 10, 20, 0, 12, 9);
		send_coords(0, 0, 10, 0, 5, 0, 5, 7);
		send_coords(0, 0, 10, 0, 10, 0, 10, 8);
		send_coords(0, 0, 10, 5, 0, 1, 10, 6);
		send_coords(0, 0, 10, 0, 4, 0, 20, 0);
		send_coords(0, 0, 10, 0, 10, 0, 20, 0);
		send_coords(0, 0, 10, 0, 11, 0, 20, 0);
		send_coords(7, -5, 7, 5, 7, 0, 7, 9);
		send_coords(7, -5, 7, 5, 7, 6, 7, 9);
		send_coords(7, -5, 7, 5, 7, 9, 7, 5);
		send_coords(4, 4, 4, 4, 0, 0, 8, 8);
		send_coords(4, 5, 4, 5, 0, 0, 8, 8);
		send_coords(0, 0, 9, 3, 6, 2, 6, 2);
		send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_coords(-32768, 0, 32767, 0, 32767, 0, -32768, 0);
		send_coords(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768);
		send_coords(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
		send_coords(-32768, -32768, 32767, 32766, 32767, 32767, -32767, -32768);
		send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_coords(-32768, -32768, -32768, 32767, -32768, 32767, -32768, -32768);
		send_coords(2, 2, 2, 2, 4, 4, 6, 6);
	endtask

	// stimulus and verdict
	initial begin
		int sent, burst, gap, waited;
		arst_n    = 1'b0;
		start     = 1'b0;
		a_start_x = '0; a_start_y = '0; a_end_x = '0; a_end_y = '0;
		b_start_x = '0; b_start_y = '0; b_end_x = '0; b_end_y = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();

		// random pairs in bursts with random gaps
		sent = 0;
		while (sent < RANDOM_PAIRS) begin
			burst = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			while (burst > 0 && sent < RANDOM_PAIRS) begin
				fill_random();
				send_pair();
				sent++;
				burst--;
			end
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;

		// drain the pipeline
		waited = 0;
		@(negedge clk);
		while (pending != 0 && waited < 200) begin
			@(negedge clk);
			waited++;
		end
		if (pending != 0) begin
			$display("segment_intersection_classify verification failed");
			$finish;
		end else begin
			repeat (8) @(posedge clk);
			if (mismatches == 0 && pending == 0)
				$display("segment_intersection_classify verification clean");
			else
				$display("segment_intersection_classify verification failed");
			$finish;
		end
	end

endmodule

// ===== files.f =====
src/sic_pkg.sv
src/sic_cross.sv
src/segment_intersection_classify.sv
test/sic_contact_check.sv
test/tb.sv
